### rtl/core/ids_pkg.sv
// Package for the image difference statistics block.
// Holds field widths, saturation limits and the structs passed between
// the pixel stage, the accumulator and the top level. Depends on nothing.
package ids_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned ABS_W      = 34;
  localparam int unsigned SQ_W       = 42;
  localparam int unsigned PIX_ABS_W  = 10;   // three channel differences
  localparam int unsigned CH_SQ_W    = 16;   // one squared channel difference
  localparam int unsigned PIX_SQ_W   = 18;   // three squared differences

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 160;

  localparam longint unsigned MAX_PIXELS = 64'd16777216;

  localparam longint unsigned CNT_MASK = (64'd1 << CNT_W) - 64'd1;
  localparam longint unsigned ABS_MASK = (64'd1 << ABS_W) - 64'd1;
  localparam longint unsigned SQ_MASK  = (64'd1 << SQ_W) - 64'd1;

  localparam longint unsigned CNT_LIM = MAX_PIXELS;
  localparam longint unsigned ABS_LIM = MAX_PIXELS * 64'd765;
  localparam longint unsigned SQ_LIM  = MAX_PIXELS * 64'd195075;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((CNT_LIM < CNT_MASK) ? CNT_LIM : CNT_MASK);
  localparam logic [ABS_W-1:0] ABS_CAP = ABS_W'((ABS_LIM < ABS_MASK) ? ABS_LIM : ABS_MASK);
  localparam logic [SQ_W-1:0]  SQ_CAP  = SQ_W'((SQ_LIM < SQ_MASK) ? SQ_LIM : SQ_MASK);

  // Per-pixel results computed in the first logic stage.
  typedef struct packed {
    logic                 frame_start;
    logic [PIX_W-1:0]     diff_red;    // already masked by the threshold
    logic [PIX_W-1:0]     diff_green;
    logic [PIX_W-1:0]     diff_blue;
    logic                 differs;
    logic [PIX_W-1:0]     peak;        // largest raw channel difference
    logic [PIX_ABS_W-1:0] abs_sum;
    logic [CH_SQ_W-1:0]   sq_red;
    logic [CH_SQ_W-1:0]   sq_green;
    logic [CH_SQ_W-1:0]   sq_blue;
  } pix_t;

  // Running totals as they stand after the last counted pixel.
  typedef struct packed {
    logic [CNT_W-1:0] count_compared;
    logic [CNT_W-1:0] count_different;
    logic [PIX_W-1:0] peak_difference;
    logic [ABS_W-1:0] total_abs;
    logic [SQ_W-1:0]  total_squares;
  } totals_t;

endpackage

### rtl/core/ids_pixel.sv
// Per-pixel difference logic: channel absolute differences, threshold test,
// pixel peak, absolute sum and squares. Combinational; uses ids_pkg.
module ids_pixel (
  input  logic [ids_pkg::IN_TDATA_W-1:0] pair_i,       // a_red..a_blue, b_red..b_blue
  input  logic                           frame_start_i,
  input  logic [ids_pkg::PIX_W-1:0]      threshold_i,
  output ids_pkg::pix_t                  pix_o
);

  logic [ids_pkg::PIX_W-1:0] d_r, d_g, d_b, m_rg;
  logic                      o_r, o_g, o_b;

  function automatic logic [ids_pkg::PIX_W-1:0] abs_diff(
    input logic [ids_pkg::PIX_W-1:0] x,
    input logic [ids_pkg::PIX_W-1:0] y
  );
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

  always_comb begin
    d_r  = abs_diff(pair_i[7:0],   pair_i[31:24]);
    d_g  = abs_diff(pair_i[15:8],  pair_i[39:32]);
    d_b  = abs_diff(pair_i[23:16], pair_i[47:40]);
    o_r  = d_r > threshold_i;
    o_g  = d_g > threshold_i;
    o_b  = d_b > threshold_i;
    m_rg = (d_g > d_r) ? d_g : d_r;

    pix_o.frame_start = frame_start_i;
    pix_o.diff_red    = o_r ? d_r : '0;
    pix_o.diff_green  = o_g ? d_g : '0;
    pix_o.diff_blue   = o_b ? d_b : '0;
    pix_o.differs     = o_r | o_g | o_b;
    pix_o.peak        = (d_b > m_rg) ? d_b : m_rg;
    pix_o.abs_sum     = ids_pkg::PIX_ABS_W'(d_r) + ids_pkg::PIX_ABS_W'(d_g)
                      + ids_pkg::PIX_ABS_W'(d_b);
    pix_o.sq_red      = ids_pkg::CH_SQ_W'(d_r) * ids_pkg::CH_SQ_W'(d_r);
    pix_o.sq_green    = ids_pkg::CH_SQ_W'(d_g) * ids_pkg::CH_SQ_W'(d_g);
    pix_o.sq_blue     = ids_pkg::CH_SQ_W'(d_b) * ids_pkg::CH_SQ_W'(d_b);
  end

endmodule

### rtl/core/ids_accum.sv
// Running totals with frame clear and saturation at the package limits.
// Updated once per pixel on load_i; uses ids_pkg.
module ids_accum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ids_pkg::pix_t   pix_i,
  output ids_pkg::totals_t totals_o
);

  logic [ids_pkg::CNT_W-1:0]    cmp_q, cmp_d, dif_q, dif_d, cmp_b, dif_b;
  logic [ids_pkg::PIX_W-1:0]    peak_q, peak_d, peak_b;
  logic [ids_pkg::ABS_W-1:0]    abs_q, abs_d, abs_b;
  logic [ids_pkg::SQ_W-1:0]     sq_q, sq_d, sq_b;
  logic [ids_pkg::CNT_W:0]      cmp_s, dif_s;
  logic [ids_pkg::ABS_W:0]      abs_s;
  logic [ids_pkg::SQ_W:0]       sq_s;
  logic [ids_pkg::PIX_SQ_W-1:0] pix_sq;

  always_comb begin
    // A frame start clears the totals before this pixel is counted.
    cmp_b  = pix_i.frame_start ? '0 : cmp_q;
    dif_b  = pix_i.frame_start ? '0 : dif_q;
    peak_b = pix_i.frame_start ? '0 : peak_q;
    abs_b  = pix_i.frame_start ? '0 : abs_q;
    sq_b   = pix_i.frame_start ? '0 : sq_q;

    pix_sq = ids_pkg::PIX_SQ_W'(pix_i.sq_red) + ids_pkg::PIX_SQ_W'(pix_i.sq_green)
           + ids_pkg::PIX_SQ_W'(pix_i.sq_blue);

    cmp_s = {1'b0, cmp_b} + (ids_pkg::CNT_W+1)'(1);
    dif_s = {1'b0, dif_b} + (ids_pkg::CNT_W+1)'(pix_i.differs);
    abs_s = {1'b0, abs_b} + (ids_pkg::ABS_W+1)'(pix_i.abs_sum);
    sq_s  = {1'b0, sq_b} + (ids_pkg::SQ_W+1)'(pix_sq);

    // Totals never exceed their caps, so a sum above the cap clips to it.
    cmp_d  = (cmp_s > {1'b0, ids_pkg::CNT_CAP}) ? ids_pkg::CNT_CAP : cmp_s[ids_pkg::CNT_W-1:0];
    dif_d  = (dif_s > {1'b0, ids_pkg::CNT_CAP}) ? ids_pkg::CNT_CAP : dif_s[ids_pkg::CNT_W-1:0];
    abs_d  = (abs_s > {1'b0, ids_pkg::ABS_CAP}) ? ids_pkg::ABS_CAP : abs_s[ids_pkg::ABS_W-1:0];
    sq_d   = (sq_s > {1'b0, ids_pkg::SQ_CAP}) ? ids_pkg::SQ_CAP : sq_s[ids_pkg::SQ_W-1:0];
    peak_d = (pix_i.peak > peak_b) ? pix_i.peak : peak_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q  <= '0;
      dif_q  <= '0;
      peak_q <= '0;
      abs_q  <= '0;
      sq_q   <= '0;
    end else if (load_i) begin
      cmp_q  <= cmp_d;
      dif_q  <= dif_d;
      peak_q <= peak_d;
      abs_q  <= abs_d;
      sq_q   <= sq_d;
    end
  end

  assign totals_o.count_compared  = cmp_q;
  assign totals_o.count_different = dif_q;
  assign totals_o.peak_difference = peak_q;
  assign totals_o.total_abs       = abs_q;
  assign totals_o.total_squares   = sq_q;

endmodule

### rtl/core/image_diff_stats.sv
// Image difference statistics: thresholded RGB difference with frame totals.
// Each item passes the input, per-pixel and output registers in order before its result shows on m_axis.
// One item per cycle while m_axis takes results; each of the three stages holds one item.
// Reset (rst_ni, async active low) empties the pipeline, clears all totals
// and sets the threshold register to zero. Uses ids_pkg, ids_pixel, ids_accum.
module image_diff_stats (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Threshold register write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ids_pkg::PIX_W-1:0]       cfg_data_i,     // threshold
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_red, a_green, a_blue, b_red, b_green, b_blue (8 bits each)
  input  logic [ids_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,   // frame_start
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // diff_red, diff_green, diff_blue (8 each), pixel_differs (1),
  // count_compared (25), count_different (25), peak_difference (8),
  // total_abs (34), total_squares (42), one zero pad bit
  output logic [ids_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // The pipeline has three registers. Stage one holds the raw pixel pair,
  // stage two holds the per-pixel differences and squares, and the output
  // stage holds the masked diff pixel. The running totals live in the
  // accumulator, which updates on the same edge that loads the output
  // stage, so it always shows the totals belonging to the result on m_axis.
  logic [ids_pkg::PIX_W-1:0]      thr_q;
  logic                           v1_q, v2_q, vo_q;
  logic [ids_pkg::IN_TDATA_W-1:0] pair_q;
  logic                           fs_q;
  ids_pkg::pix_t                  pix_d, pix_q;
  logic [ids_pkg::PIX_W-1:0]      dr_q, dg_q, db_q;
  logic                           differs_q;
  ids_pkg::totals_t               totals;
  logic                           in_acc, ld2, ld_out;

  // The user must change the threshold only while the block is idle; the block
  // itself does not enforce this, and no write ever needs to wait.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Each stage advances when the stage after it is empty or moving on,
  // which lets a new item enter every cycle while results are taken.
  assign ld_out        = v2_q && (!vo_q || m_axis_tready);
  assign ld2           = v1_q && (!v2_q || ld_out);
  assign s_axis_tready = !v1_q || ld2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (ld2) begin
        v1_q <= 1'b0;
      end
      if (ld2) begin
        v2_q <= 1'b1;
      end else if (ld_out) begin
        v2_q <= 1'b0;
      end
      if (ld_out) begin
        vo_q <= 1'b1;
      end else if (m_axis_tready) begin
        vo_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pair_q <= s_axis_tdata;
      fs_q   <= s_axis_tuser;
    end
    if (ld2) begin
      pix_q <= pix_d;
    end
    if (ld_out) begin
      dr_q      <= pix_q.diff_red;
      dg_q      <= pix_q.diff_green;
      db_q      <= pix_q.diff_blue;
      differs_q <= pix_q.differs;
    end
  end

  ids_pixel u_pixel (
    .pair_i        (pair_q),
    .frame_start_i (fs_q),
    .threshold_i   (thr_q),
    .pix_o         (pix_d)
  );

  ids_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ld_out),
    .pix_i    (pix_q),
    .totals_o (totals)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {1'b0,
                          totals.total_squares,
                          totals.total_abs,
                          totals.peak_difference,
                          totals.count_different,
                          totals.count_compared,
                          differs_q,
                          db_q,
                          dg_q,
                          dr_q};

endmodule

### rtl/core/ids_checker.sv
// Port-level checker for image_diff_stats, attached by the bind below.
// Uses ids_pkg for the count limit.
module ids_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ids_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A diff channel is nonzero exactly when the pixel is flagged as differing.
  a_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24] ==
      ((m_axis_tdata[7:0] != 8'd0) || (m_axis_tdata[15:8] != 8'd0) ||
       (m_axis_tdata[23:16] != 8'd0)))
    else $error("pixel_differs disagrees with diff pixel");

  // Differing pixels never outnumber compared pixels, which stay capped.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[74:50] <= m_axis_tdata[49:25]) &&
      (m_axis_tdata[49:25] <= ids_pkg::CNT_CAP) && (m_axis_tdata[49:25] != '0))
    else $error("pixel counts out of order");

  // The frame peak covers every shown channel difference.
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[82:75] >= m_axis_tdata[7:0]) &&
      (m_axis_tdata[82:75] >= m_axis_tdata[15:8]) &&
      (m_axis_tdata[82:75] >= m_axis_tdata[23:16]))
    else $error("peak below a channel difference");

endmodule

bind image_diff_stats ids_checker u_ids_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/image_diff_stats_tb.sv
// Self-checking testbench for image_diff_stats: streams RGB pixel pairs through
// the block and predicts every diff pixel and running frame total.
// Depends on ids_pkg and the image_diff_stats RTL only.
`timescale 1ns / 100ps

module image_diff_stats_tb;

  localparam int unsigned SETTLE_CYCLES = 4;       // settling wait after the last result
  localparam int unsigned LONG_HOLD     = 80;      // receiver hold-off in cycles
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned PHASE_COUNT   = 9;
  localparam longint unsigned TIMEOUT_NS = 64'd8_000_000;

  // Saturation limits of the totals, each capped at its field width.
  localparam longint unsigned PIXEL_LIMIT = ids_pkg::MAX_PIXELS;
  localparam longint unsigned CNT_FIELD_MAX = (64'd1 << ids_pkg::CNT_W) - 64'd1;
  localparam longint unsigned ABS_FIELD_MAX = (64'd1 << ids_pkg::ABS_W) - 64'd1;
  localparam longint unsigned SQ_FIELD_MAX  = (64'd1 << ids_pkg::SQ_W) - 64'd1;
  localparam longint unsigned COUNT_LIMIT =
    (PIXEL_LIMIT < CNT_FIELD_MAX) ? PIXEL_LIMIT : CNT_FIELD_MAX;
  localparam longint unsigned ABS_LIMIT =
    (PIXEL_LIMIT * 765 < ABS_FIELD_MAX) ? PIXEL_LIMIT * 765 : ABS_FIELD_MAX;
  localparam longint unsigned SQ_LIMIT =
    (PIXEL_LIMIT * 195075 < SQ_FIELD_MAX) ? PIXEL_LIMIT * 195075 : SQ_FIELD_MAX;

  // Bit offsets of the result fields in m_axis_tdata.
  localparam int unsigned OFS_DIFFERS   = 3 * ids_pkg::PIX_W;
  localparam int unsigned OFS_COMPARED  = OFS_DIFFERS + 1;
  localparam int unsigned OFS_DIFFERENT = OFS_COMPARED + ids_pkg::CNT_W;
  localparam int unsigned OFS_PEAK      = OFS_DIFFERENT + ids_pkg::CNT_W;
  localparam int unsigned OFS_ABS       = OFS_PEAK + ids_pkg::PIX_W;
  localparam int unsigned OFS_SQ        = OFS_ABS + ids_pkg::ABS_W;

  typedef enum int unsigned {
    READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_EVERY_THIRD
  } stall_mode_e;

  typedef enum int unsigned {
    PAIR_RANDOM, PAIR_NEAR_THRESHOLD, PAIR_EQUAL, PAIR_EXTREME
  } pair_style_e;

  typedef struct {
    logic [2:0][ids_pkg::PIX_W-1:0] diff;   // red at index 0
    logic                           differs;
    ids_pkg::totals_t               totals;
  } pixel_result_t;

  // Predicts the block's result for each accepted pixel pair and checks the
  // result items against those predictions in order.
  class pixel_diff_board;
    logic [ids_pkg::PIX_W-1:0] threshold;
    longint unsigned           compared, differing, abs_sum, square_sum;
    logic [ids_pkg::PIX_W-1:0] peak;
    pixel_result_t             expected_q[$];
    int unsigned               mismatches, results_seen;

    function new();
      threshold = '0;
      compared = 0;
      differing = 0;
      abs_sum = 0;
      square_sum = 0;
      peak = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_threshold(logic [ids_pkg::PIX_W-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function longint unsigned saturate_add(longint unsigned acc, longint unsigned inc,
                                           longint unsigned limit);
      if (acc >= limit || inc > limit - acc) return limit;
      return acc + inc;
    endfunction

    function void note_pixel(bit frame_start, logic [ids_pkg::IN_TDATA_W-1:0] pixels);
      int unsigned   d[3];
      int unsigned   a, b, pixel_peak, pixel_abs, pixel_sq;
      pixel_result_t r;
      if (frame_start) begin
        compared = 0;
        differing = 0;
        abs_sum = 0;
        square_sum = 0;
        peak = '0;
      end
      pixel_peak = 0;
      pixel_abs = 0;
      pixel_sq = 0;
      r.differs = 1'b0;
      for (int c = 0; c < 3; c++) begin
        a = pixels[c*ids_pkg::PIX_W +: ids_pkg::PIX_W];
        b = pixels[(c+3)*ids_pkg::PIX_W +: ids_pkg::PIX_W];
        d[c] = (a > b) ? a - b : b - a;
        // A channel shows only when strictly above the threshold.
        r.diff[c] = (d[c] > threshold) ? ids_pkg::PIX_W'(d[c]) : '0;
        if (d[c] > threshold) r.differs = 1'b1;
        if (d[c] > pixel_peak) pixel_peak = d[c];
        pixel_abs += d[c];
        pixel_sq += d[c] * d[c];
      end
      if (pixel_peak > peak) peak = ids_pkg::PIX_W'(pixel_peak);
      compared = saturate_add(compared, 1, COUNT_LIMIT);
      if (r.differs) differing = saturate_add(differing, 1, COUNT_LIMIT);
      abs_sum = saturate_add(abs_sum, pixel_abs, ABS_LIMIT);
      square_sum = saturate_add(square_sum, pixel_sq, SQ_LIMIT);
      r.totals.count_compared  = ids_pkg::CNT_W'(compared);
      r.totals.count_different = ids_pkg::CNT_W'(differing);
      r.totals.peak_difference = peak;
      r.totals.total_abs       = ids_pkg::ABS_W'(abs_sum);
      r.totals.total_squares   = ids_pkg::SQ_W'(square_sum);
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("%s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                  results_seen, name, got, want));
    endtask

    task check_result(logic [ids_pkg::OUT_TDATA_W-1:0] word);
      pixel_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no pixel pending",
                                  results_seen));
        return;
      end
      want = expected_q.pop_front();
      compare_field("diff_red", 64'(word[0 +: ids_pkg::PIX_W]), 64'(want.diff[0]));
      compare_field("diff_green", 64'(word[ids_pkg::PIX_W +: ids_pkg::PIX_W]),
                    64'(want.diff[1]));
      compare_field("diff_blue", 64'(word[2*ids_pkg::PIX_W +: ids_pkg::PIX_W]),
                    64'(want.diff[2]));
      compare_field("pixel_differs", 64'(word[OFS_DIFFERS]), 64'(want.differs));
      compare_field("count_compared", 64'(word[OFS_COMPARED +: ids_pkg::CNT_W]),
                    64'(want.totals.count_compared));
      compare_field("count_different", 64'(word[OFS_DIFFERENT +: ids_pkg::CNT_W]),
                    64'(want.totals.count_different));
      compare_field("peak_difference", 64'(word[OFS_PEAK +: ids_pkg::PIX_W]),
                    64'(want.totals.peak_difference));
      compare_field("total_abs", 64'(word[OFS_ABS +: ids_pkg::ABS_W]),
                    64'(want.totals.total_abs));
      compare_field("total_squares", 64'(word[OFS_SQ +: ids_pkg::SQ_W]),
                    64'(want.totals.total_squares));
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [ids_pkg::PIX_W-1:0]       cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // a_red, a_green, a_blue, b_red, b_green, b_blue
  logic [ids_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;    // frame_start
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // diffs, pixel_differs, totals, pad bit
  logic [ids_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  pixel_diff_board board;
  bit              hold_request;   // set by the stimulus, cleared by the receiver
  bit              steady_sender;  // suppresses sender gaps while set
  int unsigned     burst_left;

  image_diff_stats dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Offers one item and returns at the edge where it is accepted.
  task send_pixel(bit frame_start, logic [ids_pkg::IN_TDATA_W-1:0] pixels);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixels;
    s_axis_tuser  <= frame_start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_pixel(frame_start, pixels);
  endtask

  task send_rgb(bit frame_start, logic [ids_pkg::PIX_W-1:0] ar,
                logic [ids_pkg::PIX_W-1:0] ag, logic [ids_pkg::PIX_W-1:0] ab,
                logic [ids_pkg::PIX_W-1:0] br, logic [ids_pkg::PIX_W-1:0] bg,
                logic [ids_pkg::PIX_W-1:0] bb);
    send_pixel(frame_start, {bb, bg, br, ab, ag, ar});
  endtask

  // Bursts of random length separated by random gaps; junk data during gaps.
  task pace_sender();
    int unsigned gap;
    if (steady_sender) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= ids_pkg::IN_TDATA_W'({$urandom, $urandom});
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted result has come out.
  task wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_threshold(logic [ids_pkg::PIX_W-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.set_threshold(value);
  endtask

  // Pixel pairs biased toward the cases that matter: differences right at
  // the threshold, identical pixels and full-scale channels.
  function automatic logic [ids_pkg::IN_TDATA_W-1:0] random_pixel_pair(
    logic [ids_pkg::PIX_W-1:0] thr
  );
    logic [ids_pkg::PIX_W-1:0] a[3], b[3], swap;
    int unsigned               pick, d;
    pair_style_e               style;
    pick = $urandom_range(0, 9);
    if (pick < 5) style = PAIR_RANDOM;
    else if (pick < 8) style = PAIR_NEAR_THRESHOLD;
    else if (pick == 8) style = PAIR_EQUAL;
    else style = PAIR_EXTREME;
    for (int c = 0; c < 3; c++) begin
      case (style)
        PAIR_NEAR_THRESHOLD: begin
          case ($urandom_range(0, 4))
            0: d = thr;
            1: d = (thr == 8'd255) ? 255 : thr + 1;
            2: d = (thr == 8'd0) ? 0 : thr - 1;
            3: d = 0;
            default: d = $urandom_range(0, 255);
          endcase
          a[c] = ids_pkg::PIX_W'($urandom_range(0, 255 - d));
          b[c] = ids_pkg::PIX_W'(a[c] + d);
          if ($urandom_range(0, 1)) begin
            swap = a[c];
            a[c] = b[c];
            b[c] = swap;
          end
        end
        PAIR_EQUAL: begin
          a[c] = ids_pkg::PIX_W'($urandom_range(0, 255));
          b[c] = a[c];
        end
        PAIR_EXTREME: begin
          a[c] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          b[c] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        default: begin
          a[c] = ids_pkg::PIX_W'($urandom_range(0, 255));
          b[c] = ids_pkg::PIX_W'($urandom_range(0, 255));
        end
      endcase
    end
    return {b[2], b[1], b[0], a[2], a[1], a[0]};
  endfunction

  // Result monitor: every accepted result item is checked against the oldest
  // prediction.
  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  // Receiver: changes its stall pattern after segments of random length and honors a
  // long hold-off when the stimulus asks for one.
  initial begin : receiver
    int unsigned seg_left, tick, held;
    stall_mode_e mode;
    m_axis_tready = 1'b0;
    seg_left = 0;
    tick = 0;
    mode = READY_ALWAYS;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 120);
          mode = stall_mode_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          READY_ALWAYS:  m_axis_tready <= 1'b1;
          READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
          READY_RARELY:  m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:       m_axis_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("image_diff_stats: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned               items_left, frame_len;
    logic [ids_pkg::PIX_W-1:0] thr;
    board = new();
    hold_request = 1'b0;
    steady_sender = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Threshold at its reset value of zero. The first pixels come without
    // any frame start, so the totals run on from reset.
    send_rgb(0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_rgb(0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_rgb(0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_rgb(0, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_rgb(1, 8'd10, 8'd20, 8'd30, 8'd11, 8'd20, 8'd29);
    send_rgb(0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
    send_rgb(1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // At the top threshold no channel can ever show.
    write_threshold(8'd255);
    send_rgb(0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_rgb(1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);

    // One below the top: only a full-scale difference shows.
    write_threshold(8'd254);
    send_rgb(1, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 8'd254);
    send_rgb(0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd0);

    // Small threshold: differences equal to it stay hidden, one more shows.
    write_threshold(8'd1);
    send_rgb(1, 8'd5, 8'd5, 8'd5, 8'd6, 8'd4, 8'd5);
    send_rgb(0, 8'd5, 8'd5, 8'd5, 8'd7, 8'd5, 8'd3);
    send_rgb(0, 8'd100, 8'd100, 8'd100, 8'd100, 8'd101, 8'd103);
    send_rgb(0, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_rgb(1, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // Random phases, each under its own threshold, made of frames of
    // random length with an occasional stray or missing frame start.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: thr = 8'd0;
        1: thr = 8'd255;
        2: thr = 8'd254;
        3: thr = 8'd1;
        default: thr = ids_pkg::PIX_W'($urandom_range(0, 255));
      endcase
      write_threshold(thr);
      items_left = PHASE_ITEMS;
      if (phase == 4) begin
        // Receiver holds off while the sender keeps offering, so the
        // pipeline fills and back-pressures the input.
        hold_request = 1'b1;
        steady_sender = 1'b1;
        for (int i = 0; i < 40; i++) send_pixel(i == 0, random_pixel_pair(thr));
        steady_sender = 1'b0;
        items_left -= 40;
      end
      while (items_left > 0) begin
        frame_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
        if (frame_len > items_left) frame_len = items_left;
        for (int i = 0; i < frame_len; i++) begin
          send_pixel((i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 29) == 0),
                     random_pixel_pair(thr));
          pace_sender();
        end
        items_left -= frame_len;
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("image_diff_stats: match");
    end else begin
      $display("image_diff_stats: mismatch");
    end
    $finish;
  end

endmodule
